### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sequence reorder block.
// Depends on nothing; a module includes it where it asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is held.
`define SSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ssr assertion failed");
// Checked property that also holds during reset.
`define SSR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ssr assertion failed");
`else
`define SSR_ASSERT(lbl, prop)
`define SSR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/core/ssr_pkg.sv
// Shared types and helpers of the stream sequence reorder block.
// Depends on nothing.
package ssr_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_IN_ORDER  = 2'd0,
    STAT_UNORDERED = 2'd1,
    STAT_STALE     = 2'd2,
    STAT_DROPPED   = 2'd3
  } status_t;

  // One result item before the last-of-run mark is known.
  typedef struct packed {
    logic [15:0] ssn;
    logic [3:0]  stream;
    logic [15:0] tag;
    status_t     status;
  } res_t;

  // Serial number arithmetic: a is before b when (a - b) has bit 15 set.
  function automatic logic serial_before(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

endpackage

### rtl/core/stream_sequence_reorder.sv
// Per-stream in-order delivery engine with a sorted lobby memory.
// Depends on ssr_pkg and assert_macros.svh.
//
// One item is handled at a time. Each input item reads the stream's expected
// number from a small memory and then walks the lobby memory (one synchronous
// RAM, one read and one write port) one entry at a time, with a read step and
// an evaluate step per entry: inserting shifts the tail up one entry at a time,
// releasing shifts the tail down the same way, and a skip walks the lobby
// twice (stale pass, then run pass). Results leave through an output register
// and a one-deep holding stage; an item closes once its last result has moved
// into the output register, so a receiver that holds off long enough also
// holds off the next item.
`include "assert_macros.svh"

module stream_sequence_reorder
  import ssr_pkg::*;
#(
  parameter int NUM_STREAMS   = 16,
  parameter int LOBBY_ENTRIES = 32,
  parameter int TAG_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // stream_id[3:0], ssn_number[19:4], event_tag[35:20]
  input  logic [1:0]  in_tuser,   // func[0], unordered[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_tag[15:0], out_stream[19:16], out_ssn[35:20]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast   // last_of_run
);

  localparam int LW = $clog2(LOBBY_ENTRIES);
  localparam int CW = $clog2(LOBBY_ENTRIES + 1);

  typedef struct packed {
    logic [TAG_BITS-1:0] handle;
    logic [15:0]         seq;
    logic [3:0]          stream;
  } lentry_t;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_EXP     = 12'b000000000010,
    S_TAIL    = 12'b000000000100,
    S_SCAN_RD = 12'b000000001000,
    S_SCAN_EV = 12'b000000010000,
    S_SH_RD   = 12'b000000100000,
    S_SH_WR   = 12'b000001000000,
    S_PUT     = 12'b000010000000,
    S_WALK_RD = 12'b000100000000,
    S_WALK_EV = 12'b001000000000,
    S_REM_RD  = 12'b010000000000,
    S_REM_WR  = 12'b100000000000
  } state_t;

  // The finish step is folded into a flag so the enum stays compact.
  state_t         st_r, st_nxt;
  logic           fin_r, fin_nxt;
  logic           func_r, unord_r;
  logic [3:0]     sid_r;
  logic [15:0]    ssn_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [15:0]    exp_r, exp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic           run_r, run_nxt;
  logic           pend_v_r, pend_v_nxt;
  res_t           pend_r, pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  res_t           out_r, out_nxt;
  logic           out_last_r, out_last_nxt;

  // Lobby memory.
  lentry_t        lb_mem [LOBBY_ENTRIES];
  lentry_t        lb_rd_r;
  logic [LW-1:0]  lb_ra, lb_wa;
  logic           lb_we;
  lentry_t        lb_wd;

  // Expected-number memory with per-entry valid bits for the reset value.
  logic [15:0]    exp_mem [16];
  logic [15:0]    exp_rd_r;
  logic [15:0]    exp_vld_r;
  logic           exp_we;

  logic           in_acc, out_room, can_emit, emit_en, fin_push;
  res_t           emit_res;
  logic [15:0]    exp_cur;
  logic           in_range, walk_hit;

  assign in_tready = (st_r == S_IDLE) && !fin_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_room  = !out_valid_r || out_tready;
  assign can_emit  = !pend_v_r || out_room;
  assign exp_cur   = exp_vld_r[sid_r] ? exp_rd_r : 16'd0;
  assign in_range  = (32'(sid_r) < NUM_STREAMS);
  assign walk_hit  = run_r ? (lb_rd_r.seq == exp_r) : serial_before(lb_rd_r.seq, exp_r);

  // Sequencer.
  always_comb begin
    st_nxt   = st_r;
    fin_nxt  = fin_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    pos_nxt  = pos_r;
    k_nxt    = k_r;
    run_nxt  = run_r;
    lb_ra    = idx_r[LW-1:0];
    lb_wa    = idx_r[LW-1:0];
    lb_we    = 1'b0;
    lb_wd    = lb_rd_r;
    exp_we   = 1'b0;
    emit_en  = 1'b0;
    fin_push = 1'b0;
    emit_res = '{ssn: ssn_r, stream: sid_r, tag: 16'(tag_r), status: STAT_IN_ORDER};

    if (fin_r) begin
      // Write back the expected number and close the run.
      exp_we = 1'b1;
      if (!pend_v_r) begin
        fin_nxt = 1'b0;
      end else if (out_room) begin
        fin_push = 1'b1;
        fin_nxt  = 1'b0;
      end
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) st_nxt = S_EXP;
        end
        S_EXP: begin
          exp_nxt = exp_cur;
          lb_ra   = LW'(cnt_r - 1'b1);
          st_nxt  = S_IDLE;
          if (!func_r && unord_r) begin
            emit_en         = 1'b1;
            emit_res.status = STAT_UNORDERED;
            fin_nxt         = 1'b1;
          end else if (!in_range) begin
            fin_nxt = 1'b1;
          end else if (!func_r) begin
            if (ssn_r != exp_cur) begin
              if (cnt_r >= CW'(LOBBY_ENTRIES)) begin
                emit_en         = 1'b1;
                emit_res.status = STAT_DROPPED;
                fin_nxt         = 1'b1;
              end else if (cnt_r == '0) begin
                pos_nxt = '0;
                idx_nxt = '0;
                st_nxt  = S_SH_RD;
              end else begin
                st_nxt = S_TAIL;
              end
            end else begin
              exp_nxt = ssn_r + 16'd1;
              emit_en = 1'b1;
              run_nxt = 1'b1;
              idx_nxt = '0;
              st_nxt  = S_WALK_RD;
            end
          end else if (serial_before(ssn_r, exp_cur)) begin
            fin_nxt = 1'b1;
          end else begin
            exp_nxt = ssn_r + 16'd1;
            run_nxt = 1'b0;
            idx_nxt = '0;
            st_nxt  = S_WALK_RD;
          end
        end
        // Tail shortcut: append when the item sorts after the last entry.
        S_TAIL: begin
          if (sid_r > lb_rd_r.stream ||
              (sid_r == lb_rd_r.stream && serial_before(lb_rd_r.seq, ssn_r))) begin
            pos_nxt = cnt_r;
            idx_nxt = cnt_r;
            st_nxt  = S_SH_RD;
          end else begin
            idx_nxt = '0;
            st_nxt  = S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx_r == cnt_r) begin
            pos_nxt = cnt_r;
            st_nxt  = S_SH_RD;
          end else begin
            st_nxt = S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (lb_rd_r.stream > sid_r ||
              (lb_rd_r.stream == sid_r && serial_before(ssn_r, lb_rd_r.seq))) begin
            pos_nxt = idx_r;
            idx_nxt = cnt_r;
            st_nxt  = S_SH_RD;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = S_SCAN_RD;
          end
        end
        // Open a hole at the insert position, moving the tail up by one.
        S_SH_RD: begin
          lb_ra = LW'(idx_r - 1'b1);
          st_nxt = (idx_r == pos_r) ? S_PUT : S_SH_WR;
        end
        S_SH_WR: begin
          lb_we   = 1'b1;
          idx_nxt = idx_r - 1'b1;
          st_nxt  = S_SH_RD;
        end
        S_PUT: begin
          lb_we   = 1'b1;
          lb_wa   = pos_r[LW-1:0];
          lb_wd   = '{handle: tag_r, seq: ssn_r, stream: sid_r};
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = S_IDLE;
          fin_nxt = 1'b1;
        end
        // Release walk: stale pass for a skip, then the consecutive run.
        S_WALK_RD: begin
          if (idx_r >= cnt_r) begin
            if (!run_r) begin
              run_nxt = 1'b1;
              idx_nxt = '0;
            end else begin
              st_nxt  = S_IDLE;
              fin_nxt = 1'b1;
            end
          end else begin
            st_nxt = S_WALK_EV;
          end
        end
        S_WALK_EV: begin
          if (lb_rd_r.stream < sid_r) begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = S_WALK_RD;
          end else if (lb_rd_r.stream > sid_r || !walk_hit) begin
            if (!run_r) begin
              run_nxt = 1'b1;
              idx_nxt = '0;
              st_nxt  = S_WALK_RD;
            end else begin
              st_nxt  = S_IDLE;
              fin_nxt = 1'b1;
            end
          end else if (can_emit) begin
            emit_en  = 1'b1;
            emit_res = '{ssn: lb_rd_r.seq, stream: sid_r, tag: 16'(lb_rd_r.handle),
                         status: (run_r ? STAT_IN_ORDER : STAT_STALE)};
            if (run_r) exp_nxt = exp_r + 16'd1;
            k_nxt  = idx_r;
            st_nxt = S_REM_RD;
          end
        end
        // Close the gap left by a released entry.
        S_REM_RD: begin
          lb_ra = LW'(k_r + 1'b1);
          if (CW'(k_r + 1'b1) >= cnt_r) begin
            cnt_nxt = cnt_r - 1'b1;
            st_nxt  = S_WALK_RD;
          end else begin
            st_nxt = S_REM_WR;
          end
        end
        S_REM_WR: begin
          lb_we  = 1'b1;
          lb_wa  = k_r[LW-1:0];
          k_nxt  = k_r + 1'b1;
          st_nxt = S_REM_RD;
        end
        default: st_nxt = S_IDLE;
      endcase
    end
  end

  // Holding stage and output register.
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (emit_en) begin
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end
    if (fin_push) begin
      out_nxt       = pend_r;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      exp_vld_r   <= '0;
    end else begin
      st_r        <= st_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (exp_we) exp_vld_r[sid_r] <= 1'b1;
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_tuser[0];
      unord_r <= in_tuser[1];
      sid_r   <= in_tdata[3:0];
      ssn_r   <= in_tdata[19:4];
      tag_r   <= TAG_BITS'(in_tdata[35:20]);
    end
    exp_r      <= exp_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    run_r      <= run_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // Lobby memory with a registered read port.
  always_ff @(posedge clk) begin
    if (lb_we) lb_mem[lb_wa] <= lb_wd;
    lb_rd_r <= lb_mem[lb_ra];
  end

  // Expected-number memory, read at the incoming item's stream.
  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[sid_r] <= exp_r;
    exp_rd_r <= exp_mem[in_tdata[3:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.ssn, out_r.stream, out_r.tag};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_last_r;

  `SSR_ASSERT(a_cnt_bound, cnt_r <= CW'(LOBBY_ENTRIES))
  `SSR_ASSERT(a_idle_no_pend, (st_r == S_IDLE && !fin_r) |-> !pend_v_r)
  `SSR_ASSERT(a_put_grows, (st_r == S_PUT && !fin_r) |=> cnt_r == $past(cnt_r) + 1'b1)
  `SSR_ASSERT(a_emit_safe, (emit_en && pend_v_r) |-> out_room)
  `SSR_ASSERT_ALWAYS(a_state_onehot, $onehot(st_r) || !rst_n)

endmodule
